### rtl/plis_pkg.sv
// Package: operation and status codes, request, response and cell command types.
`default_nettype none
package plis_pkg;

    localparam int unsigned CAPACITY_DEF = 16;

    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_RETRIEVE = 3'd2;
    localparam logic [2:0] OP_REPLACE  = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;
    localparam logic [2:0] OP_SORT     = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] position;
        t_word      value;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        t_word      read_value;
        logic [4:0] fill_count;
        logic       is_full;
        logic       is_empty;
    } t_rsp;

    typedef struct packed {
        logic       ins;
        logic       rem;
        logic       wr;
        logic       sort_en;
        logic       phase;
        logic [4:0] pos;
        t_word      value;
    } t_cell_cmd;

endpackage
`default_nettype wire

### rtl/positional_list_with_insertion_sort_unit.sv
// Top level: positional list of signed entries in a row of slot cells, with sort sequencer.
//
// For insert, remove, retrieve, replace and clear, the request is taken
// at an edge with start high and busy low, and its result strobes on
// o_done for one cycle in the next cycle, so a new request may follow
// every cycle. Sort runs an odd-even transposition pass over the slot
// cells, one phase per cycle, for as many phases as entries are held;
// busy stays high through the last phase (it does not rise for fewer than
// two entries) and the result strobes in the cycle after the last phase.
// Equal entries keep their order. The receiver must take each result in
// its strobe cycle.
`default_nettype none
module positional_list_with_insertion_sort_unit #(
    parameter int CAPACITY = plis_pkg::CAPACITY_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  plis_pkg::t_req i_req,
    output logic           o_done,
    output plis_pkg::t_rsp o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_SORT = 1'b1;

    logic                r_state;
    logic                n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW-1:0]       r_left;
    logic [CW-1:0]       n_left;
    logic                r_phase;
    logic                n_phase;
    logic                r_done;
    logic                n_done;
    plis_pkg::t_rsp      r_rsp;
    plis_pkg::t_rsp      n_rsp;
    plis_pkg::t_cell_cmd cmd;
    plis_pkg::t_word     cell_val [CAPACITY];
    plis_pkg::t_word     rd_sel;
    logic                accept;
    logic [1:0]          status;
    plis_pkg::t_word     rd;

    assign accept = start && !busy;

    always_comb begin
        rd_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (int'(i_req.position) == i) begin
                rd_sel = cell_val[i];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_phase     = r_phase;
        n_done      = 1'b0;
        status      = plis_pkg::ST_OK;
        rd          = '0;
        cmd         = '0;
        cmd.pos     = i_req.position;
        cmd.value   = i_req.value;
        cmd.phase   = r_phase;
        if (r_state == S_SORT) begin
            cmd.sort_en = 1'b1;
            n_phase     = ~r_phase;
            n_left      = r_left - CW'(1);
            if (r_left == CW'(1)) begin
                n_state = S_IDLE;
                n_done  = 1'b1;
            end
        end else if (accept) begin
            n_done = 1'b1;
            case (i_req.op)
                plis_pkg::OP_INSERT: begin
                    if (int'(i_req.position) > int'(r_count)) begin
                        status = plis_pkg::ST_RANGE;
                    end else if (r_count == CW'(CAPACITY)) begin
                        status = plis_pkg::ST_OVER;
                    end else begin
                        cmd.ins = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                plis_pkg::OP_REMOVE: begin
                    if (int'(i_req.position) >= int'(r_count)) begin
                        status = plis_pkg::ST_RANGE;
                    end else begin
                        cmd.rem = 1'b1;
                        rd      = rd_sel;
                        n_count = r_count - CW'(1);
                    end
                end
                plis_pkg::OP_RETRIEVE: begin
                    if (int'(i_req.position) >= int'(r_count)) begin
                        status = plis_pkg::ST_RANGE;
                    end else begin
                        rd = rd_sel;
                    end
                end
                plis_pkg::OP_REPLACE: begin
                    if (int'(i_req.position) >= int'(r_count)) begin
                        status = plis_pkg::ST_RANGE;
                    end else begin
                        cmd.wr = 1'b1;
                    end
                end
                plis_pkg::OP_CLEAR: begin
                    n_count = '0;
                end
                plis_pkg::OP_SORT: begin
                    if (r_count >= CW'(2)) begin
                        n_done  = 1'b0;
                        n_state = S_SORT;
                        n_left  = r_count;
                        n_phase = 1'b0;
                    end
                end
                default: begin
                    status = plis_pkg::ST_RANGE;
                end
            endcase
        end
        n_rsp.status     = status;
        n_rsp.read_value = rd;
        n_rsp.fill_count = 5'(n_count);
        n_rsp.is_full    = n_count == CW'(CAPACITY);
        n_rsp.is_empty   = n_count == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
        r_left  <= n_left;
        r_phase <= n_phase;
        r_rsp   <= n_rsp;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        plis_pkg::t_word lower;
        plis_pkg::t_word upper;
        if (g == 0) begin : g_lo
            assign lower = '0;
        end else begin : g_lo
            assign lower = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_hi
            assign upper = '0;
        end else begin : g_hi
            assign upper = cell_val[g+1];
        end
        plis_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_count (r_count),
            .i_lower (lower),
            .i_upper (upper),
            .o_val   (cell_val[g])
        );
    end

    assign busy   = r_state == S_SORT;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_done_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.op != plis_pkg::OP_SORT |=> o_done)
        else $error("non-sort transfer gave no result");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count above capacity");
    a_quiet_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_done)
        else $error("result strobe while sorting");
    a_sort_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> r_count >= CW'(2))
        else $error("sort started on fewer than two entries");

endmodule
`default_nettype wire

### rtl/plis_cell.sv
// One list slot: holds an entry, shifts with its neighbors, does compare-exchange for sort.
`default_nettype none
module plis_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire                   i_clk,
    input  plis_pkg::t_cell_cmd   i_cmd,
    input  wire  [CW-1:0]         i_count,
    input  plis_pkg::t_word       i_lower,
    input  plis_pkg::t_word       i_upper,
    output plis_pkg::t_word       o_val
);

    plis_pkg::t_word r_val;
    plis_pkg::t_word n_val;
    logic above;
    logic at;
    logic left_act;
    logic right_act;

    always_comb begin
        above     = IDX > int'(i_cmd.pos);
        at        = IDX == int'(i_cmd.pos);
        left_act  = i_cmd.sort_en && ((IDX % 2) == int'(i_cmd.phase))
                    && (IDX + 1 < int'(i_count));
        right_act = i_cmd.sort_en && (IDX >= 1) && (((IDX + 1) % 2) == int'(i_cmd.phase))
                    && (IDX < int'(i_count));
        n_val = r_val;
        if (i_cmd.ins) begin
            if (above) begin
                n_val = i_lower;
            end else if (at) begin
                n_val = i_cmd.value;
            end
        end else if (i_cmd.rem) begin
            if (above || at) begin
                n_val = i_upper;
            end
        end else if (i_cmd.wr) begin
            if (at) begin
                n_val = i_cmd.value;
            end
        end else if (left_act) begin
            if (r_val > i_upper) begin
                n_val = i_upper;
            end
        end else if (right_act) begin
            if (i_lower > r_val) begin
                n_val = i_lower;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule
`default_nettype wire
